// ----- hw/rtl/asmg_pkg.sv -----
package asmg_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned GAIN_W   = 11;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // Q10 gain: the top bit alone means unity or above, which skips the multiply.
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 11'd1024;
  localparam int unsigned       GAIN_FRAC  = 10;

  typedef enum logic [1:0] {
    FMT_S16 = 2'd0,
    FMT_S24 = 2'd1,
    FMT_S32 = 2'd2
  } fmt_e;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_GAIN   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] src;
    logic [SAMPLE_W-1:0] snk;
    logic                add;
    logic                last;
  } mix_item_t;

endpackage

// ----- hw/rtl/audio_sample_mix_with_gain.sv -----
// Path: an input transfer is captured in the input register, then passes the
//   gain register and the output register before it is offered on the output port.
// Throughput: one sample per cycle unless the output stalls; the input, gain
//   and output registers each hold one sample, so stalls back up stage by stage.
// Reset: rst_ni clears all valid flags, sets the format to 32-bit and the gain
//   to unity; sample registers are not reset.
module audio_sample_mix_with_gain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asmg_pkg::ADDR_W-1:0]   paddr,
  input  logic [asmg_pkg::DATA_W-1:0]   pwdata,
  output logic [asmg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [asmg_pkg::SAMPLE_W-1:0] source_sample_i,
  input  logic [asmg_pkg::SAMPLE_W-1:0] sink_sample_i,
  input  logic                          add_to_sink_i,
  input  logic                          last_in_block_i,
  // mixed output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [asmg_pkg::SAMPLE_W-1:0] mixed_sample_o,
  output logic                          block_end_o
);

  logic [1:0]                  fmt;
  logic [asmg_pkg::GAIN_W-1:0] gain;

  // Gain stage to sum stage
  logic                mid_valid;
  logic                mid_ready;
  asmg_pkg::mix_item_t mid_item;

  // Format and gain; the user must write them only while no sample is in flight
  // (the block does not enforce this), so every stage may read them live.
  asmg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fmt_o   (fmt),
    .gain_o  (gain)
  );

  // Capture the transfer, sign-extend per format, then scale the source by the
  // gain (bypass at unity or above) into the middle register.
  asmg_gain_stage u_gain (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .source_sample_i (source_sample_i),
    .sink_sample_i   (sink_sample_i),
    .add_to_sink_i   (add_to_sink_i),
    .last_in_block_i (last_in_block_i),
    .fmt_i           (fmt),
    .gain_i          (gain),
    .out_valid_o     (mid_valid),
    .out_ready_i     (mid_ready),
    .out_item_o      (mid_item)
  );

  // Add to the sink sample with saturation or copy, and hold the result in the
  // output register until the downstream transfer.
  asmg_sum_stage u_sum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (mid_valid),
    .in_ready_o     (mid_ready),
    .in_item_i      (mid_item),
    .fmt_i          (fmt),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mixed_sample_o (mixed_sample_o),
    .block_end_o    (block_end_o)
  );

endmodule

// ----- hw/rtl/asmg_cfg_regs.sv -----
module asmg_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [asmg_pkg::ADDR_W-1:0]     paddr,
  input  logic [asmg_pkg::DATA_W-1:0]     pwdata,
  output logic [asmg_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output logic [1:0]                      fmt_o,
  output logic [asmg_pkg::GAIN_W-1:0]     gain_o
);

  logic [1:0]                  fmt_q;
  logic [asmg_pkg::GAIN_W-1:0] gain_q;
  logic                        wr_en;
  asmg_pkg::reg_e              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = asmg_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= asmg_pkg::FMT_S32;
      gain_q <= asmg_pkg::UNITY_GAIN;
    end else if (wr_en) begin
      case (reg_sel)
        asmg_pkg::REG_FORMAT: fmt_q  <= pwdata[1:0];
        asmg_pkg::REG_GAIN:   gain_q <= pwdata[asmg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      asmg_pkg::REG_FORMAT: prdata[1:0] = fmt_q;
      asmg_pkg::REG_GAIN:   prdata[asmg_pkg::GAIN_W-1:0] = gain_q;
      default: ;
    endcase
  end

  assign fmt_o  = fmt_q;
  assign gain_o = gain_q;

endmodule

// ----- hw/rtl/asmg_gain_stage.sv -----
module asmg_gain_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [asmg_pkg::SAMPLE_W-1:0]     source_sample_i,
  input  logic [asmg_pkg::SAMPLE_W-1:0]     sink_sample_i,
  input  logic                              add_to_sink_i,
  input  logic                              last_in_block_i,
  input  logic [1:0]                        fmt_i,
  input  logic [asmg_pkg::GAIN_W-1:0]       gain_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output asmg_pkg::mix_item_t               out_item_o
);

  localparam int unsigned PROD_W = asmg_pkg::SAMPLE_W + asmg_pkg::GAIN_W;

  logic                a_valid_q, b_valid_q;
  asmg_pkg::mix_item_t a_item_q, b_item_q, b_item_d;
  logic                a_ready, b_ready;

  logic signed [asmg_pkg::SAMPLE_W-1:0] src_ext, snk_ext;
  logic signed [PROD_W-1:0]             prod, prod_rnd;
  logic signed [asmg_pkg::GAIN_W-1:0]   gain_s;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Sign-extend both samples from the format's top bit.
  always_comb begin
    case (fmt_i)
      asmg_pkg::FMT_S16: begin
        src_ext = {{16{a_item_q.src[15]}}, a_item_q.src[15:0]};
        snk_ext = {{16{a_item_q.snk[15]}}, a_item_q.snk[15:0]};
      end
      asmg_pkg::FMT_S24: begin
        src_ext = {{8{a_item_q.src[23]}}, a_item_q.src[23:0]};
        snk_ext = {{8{a_item_q.snk[23]}}, a_item_q.snk[23:0]};
      end
      default: begin
        src_ext = a_item_q.src;
        snk_ext = a_item_q.snk;
      end
    endcase
  end

  // Q1.15 and Q1.23 gains are the Q10 gain shifted up, so round at bit 10.
  // The magnitude never grows, so the result already fits the format.
  assign gain_s   = $signed({1'b0, gain_i[asmg_pkg::GAIN_W-2:0]});
  assign prod     = src_ext * gain_s;
  assign prod_rnd = prod + PROD_W'(signed'(1 << (asmg_pkg::GAIN_FRAC - 1)));

  always_comb begin
    b_item_d      = a_item_q;
    b_item_d.snk  = snk_ext;
    if (gain_i[asmg_pkg::GAIN_W-1]) begin
      b_item_d.src = src_ext;
    end else begin
      b_item_d.src = prod_rnd[asmg_pkg::GAIN_FRAC +: asmg_pkg::SAMPLE_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_item_q.src  <= source_sample_i;
      a_item_q.snk  <= sink_sample_i;
      a_item_q.add  <= add_to_sink_i;
      a_item_q.last <= last_in_block_i;
    end
    if (a_valid_q && b_ready) begin
      b_item_q <= b_item_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

endmodule

// ----- hw/rtl/asmg_sum_stage.sv -----
module asmg_sum_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  asmg_pkg::mix_item_t               in_item_i,
  input  logic [1:0]                        fmt_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [asmg_pkg::SAMPLE_W-1:0]     mixed_sample_o,
  output logic                              block_end_o
);

  localparam int unsigned SUM_W = asmg_pkg::SAMPLE_W + 1;

  logic                          out_valid_q;
  logic [asmg_pkg::SAMPLE_W-1:0] mixed_q, mixed_d;
  logic                          last_q;
  logic                          ready;

  logic signed [SUM_W-1:0] sum, hi, lo, sat;

  assign ready      = !out_valid_q || out_ready_i;
  assign in_ready_o = ready;

  assign sum = $signed({in_item_i.src[asmg_pkg::SAMPLE_W-1], in_item_i.src})
             + $signed({in_item_i.snk[asmg_pkg::SAMPLE_W-1], in_item_i.snk});

  always_comb begin
    case (fmt_i)
      asmg_pkg::FMT_S16: begin
        hi = SUM_W'(signed'(32767));
        lo = -SUM_W'(signed'(32768));
      end
      asmg_pkg::FMT_S24: begin
        hi = SUM_W'(signed'(8388607));
        lo = -SUM_W'(signed'(8388608));
      end
      default: begin
        hi = SUM_W'(signed'(2147483647));
        lo = -SUM_W'(64'sd2147483648);
      end
    endcase
    if (sum > hi) begin
      sat = hi;
    end else if (sum < lo) begin
      sat = lo;
    end else begin
      sat = sum;
    end
    mixed_d = in_item_i.add ? sat[asmg_pkg::SAMPLE_W-1:0] : in_item_i.src;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready) begin
      mixed_q <= mixed_d;
      last_q  <= in_item_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mixed_q;
  assign block_end_o    = last_q;

endmodule

// ----- hw/rtl/asmg_checker.sv -----
module asmg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [asmg_pkg::ADDR_W-1:0]   paddr,
  input logic [asmg_pkg::DATA_W-1:0]   pwdata,
  input logic                          pready,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [asmg_pkg::SAMPLE_W-1:0] mixed_sample_o,
  input logic                          block_end_o
);

  logic       in_xfer, out_xfer, wr_fmt;
  logic [2:0] pending_q;
  logic [1:0] fmt_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign wr_fmt   = psel && penable && pwrite && pready
                  && (paddr[2] == asmg_pkg::REG_FORMAT);

  // Track samples in flight and the format as written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      fmt_q     <= asmg_pkg::FMT_S32;
    end else begin
      pending_q <= pending_q + 3'(in_xfer) - 3'(out_xfer);
      if (wr_fmt) begin
        fmt_q <= pwdata[1:0];
      end
    end
  end

  a_pending_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more than three samples in flight");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result offered with no sample in flight");

  a_s16_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fmt_q == asmg_pkg::FMT_S16)
      |-> mixed_sample_o[31:15] == {17{mixed_sample_o[15]}})
    else $error("16-bit result not sign-extended");

  a_s24_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fmt_q == asmg_pkg::FMT_S24)
      |-> mixed_sample_o[31:23] == {9{mixed_sample_o[23]}})
    else $error("24-bit result not sign-extended");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i)
      |=> out_valid_o && $stable(mixed_sample_o) && $stable(block_end_o))
    else $error("stalled result changed");

endmodule

bind audio_sample_mix_with_gain asmg_checker u_asmg_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
  import asmg_pkg::*;

  // Pipeline depth from input transfer to output transfer.
  localparam int unsigned PIPE_LATENCY   = 3;
  // Gain scaling: Q10 becomes Q1.15 (shift by 5) or, for 24-bit samples, Q1.23 (shift by 13).
  localparam int unsigned Q15_GAIN_SHIFT = 5;
  localparam int unsigned Q23_GAIN_SHIFT = 13;
  localparam int unsigned Q15_FRAC       = 15;
  localparam int unsigned Q23_FRAC       = 23;
  // Format code outside the enum; the block treats it as 32-bit.
  localparam logic [1:0]  FMT_UNUSED     = 2'd3;
  localparam logic [10:0] GAIN_ZERO      = 11'd0;
  localparam logic [10:0] GAIN_REG_MAX   = 11'h7FF;
  localparam int unsigned RANDOM_ITEMS   = 690;
  localparam int unsigned HOLD_CYCLES    = 64;
  localparam int unsigned DRAIN_LIMIT    = 2000;
  localparam int unsigned MAX_PRINTS     = 200;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] source_sample_i;
  logic [SAMPLE_W-1:0] sink_sample_i;
  logic                add_to_sink_i;
  logic                last_in_block_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [SAMPLE_W-1:0] mixed_sample_o;
  logic                block_end_o;

  // One expected output transfer.
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } mix_result_t;

  mix_result_t pending_mix_q[$];

  // Shadow copies of the two registers, kept in step with every write.
  logic [1:0]  fmt_cfg;
  logic [10:0] gain_cfg;

  int unsigned error_count;
  int unsigned samples_sent;
  int unsigned results_checked;
  int unsigned settings_used;
  int unsigned input_stall_cycles;

  // Idle control shared by the sender and the output ready process; hold-off state.
  bit          idle_on;
  bit          hold_request;
  int unsigned hold_left;

  audio_sample_mix_with_gain i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .source_sample_i (source_sample_i),
    .sink_sample_i   (sink_sample_i),
    .add_to_sink_i   (add_to_sink_i),
    .last_in_block_i (last_in_block_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mixed_sample_o  (mixed_sample_o),
    .block_end_o     (block_end_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned fmt_bits(input logic [1:0] fmt);
    case (fmt)
      FMT_S16: return 16;
      FMT_S24: return 24;
      default: return 32;
    endcase
  endfunction

  // Sign-extend the low w bits of v.
  function automatic longint sext_to(input logic [31:0] v, input int unsigned w);
    logic [31:0] t;
    t = v << (32 - w);
    return longint'($signed(t)) >>> (32 - w);
  endfunction

  function automatic longint clamp_to_width(input longint v, input int unsigned w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Scale the source by the gain (skipped at unity or above), then add to the
  // sink with saturation or pass the scaled source on as is.
  function automatic logic [31:0] mixed_value(input logic [1:0] fmt, input logic [10:0] gain,
                                               input logic [31:0] src, input logic [31:0] snk,
                                               input logic add);
    int unsigned w;
    int unsigned frac;
    int unsigned gshift;
    longint      s;
    longint      k;
    longint      gq;
    longint      prod;
    logic [10:0] g;
    w      = fmt_bits(fmt);
    frac   = (fmt == FMT_S24) ? Q23_FRAC : Q15_FRAC;
    gshift = (fmt == FMT_S24) ? Q23_GAIN_SHIFT : Q15_GAIN_SHIFT;
    s      = sext_to(src, w);
    k      = sext_to(snk, w);
    g      = (gain > UNITY_GAIN) ? UNITY_GAIN : gain;
    if (g != UNITY_GAIN) begin
      gq   = clamp_to_width(longint'(g) << gshift, frac + 1);
      // Round half up: add half an LSB, then shift right arithmetically.
      prod = s * gq + (longint'(1) << (frac - 1));
      s    = clamp_to_width(prod >>> frac, w);
    end
    if (add) s = clamp_to_width(s + k, w);
    return s[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 99) < 8) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Full-scale corners, sign boundaries of each format and junk in the upper bits.
  function automatic logic [31:0] extreme_value(input int unsigned k);
    case (k % 10)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return 32'h0000_7FFF;
      5: return 32'hFFFF_8000;
      6: return 32'h007F_FFFF;
      7: return 32'hFF80_0000;
      8: return 32'hA5A5_8001;
      default: return 32'h5A80_0001;
    endcase
  endfunction

  // Random sample aimed at saturation now and then; upper unused bits stay random.
  function automatic logic [31:0] random_sample(input logic [1:0] fmt);
    int unsigned w;
    logic [31:0] mask;
    logic [31:0] core;
    logic [31:0] r;
    w    = fmt_bits(fmt);
    mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    r    = $urandom;
    case ($urandom_range(0, 5))
      0:       core = (32'd1 << (w - 1)) - 32'd1 - $urandom_range(0, 255);
      1:       core = (32'd1 << (w - 1)) + $urandom_range(0, 255);
      2:       core = $urandom_range(0, 2000) - 1000;
      default: core = $urandom;
    endcase
    return (r & ~mask) | (core & mask);
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  // Read a register and compare with the expected value. Start and end on a
  // falling edge; the bus is released before the task returns.
  task automatic apb_read_check(input reg_e idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      report_mismatch($sformatf("register %s read %h, expected %h", idx.name(), prdata, want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write a register (setup, then access), update the shadow, read it back.
  task automatic apb_write_reg(input reg_e idx, input logic [31:0] value);
    logic [31:0] kept;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);
    if (idx == REG_FORMAT) begin
      fmt_cfg = value[1:0];
      kept    = {30'd0, value[1:0]};
    end else begin
      gain_cfg = value[10:0];
      kept     = {21'd0, value[10:0]};
    end
    apb_read_check(idx, kept);
  endtask

  // Drop valid, wait for every expected transfer, then let the pipe settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_mix_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [1:0] fmt, input logic [10:0] gain);
    wait_drained();
    apb_write_reg(REG_FORMAT, {30'd0, fmt});
    apb_write_reg(REG_GAIN, {21'd0, gain});
    settings_used++;
  endtask

  // Offer one sample and hold it until the transfer. Valid stays high on
  // return so that back-to-back samples need no drop; the next call or
  // wait_drained() decides whether to lower it. Start and end on a falling edge.
  task automatic send_sample(input logic [31:0] src, input logic [31:0] snk,
                             input logic add, input logic last);
    int unsigned gap;
    mix_result_t want;
    gap = (idle_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    source_sample_i <= src;
    sink_sample_i   <= snk;
    add_to_sink_i   <= add;
    last_in_block_i <= last;
    do begin
      @(posedge clk_i);
      if (!in_ready_o) input_stall_cycles++;
    end while (!in_ready_o);
    want.sample = mixed_value(fmt_cfg, gain_cfg, src, snk, add);
    want.last   = last;
    pending_mix_q.push_back(want);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready driver and result checker
  // ---------------------------------------------------------------------------

  // Drive ready at the falling edge. A requested hold-off keeps ready low for
  // HOLD_CYCLES so that the pipe fills and backs up into the input.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      hold_left    = gap_len() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    mix_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_mix_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", mixed_sample_o));
      end else begin
        want = pending_mix_q.pop_front();
        results_checked++;
        if (mixed_sample_o !== want.sample)
          report_mismatch($sformatf("mixed_sample %h, expected %h (fmt %0d gain %0d)",
                                    mixed_sample_o, want.sample, fmt_cfg, gain_cfg));
        if (block_end_o !== want.last)
          report_mismatch($sformatf("block_end %b, expected %b", block_end_o, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Check the register values right after reset and mix a couple of samples there.
  task automatic test_reset_values();
    fmt_cfg  = FMT_S32;
    gain_cfg = UNITY_GAIN;
    apb_read_check(REG_FORMAT, {30'd0, FMT_S32});
    apb_read_check(REG_GAIN, {21'd0, UNITY_GAIN});
    send_sample(32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 1'b0);
    send_sample(32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
  endtask

  // Three corner samples per setting: add twice, then copy with the block mark.
  task automatic directed_burst(input int unsigned k);
    for (int unsigned i = 0; i < 3; i++)
      send_sample(extreme_value(3 * k + i), extreme_value(7 * k + 2 * i + 1), i != 2, i == 2);
  endtask

  // Walk the corners of both registers: unity, zero, half and near-unity gain, the
  // smallest gain, gains above unity and the unused format code.
  task automatic test_directed();
    apply_setting(FMT_S32, UNITY_GAIN);   directed_burst(0);
    apply_setting(FMT_S16, GAIN_ZERO);    directed_burst(1);
    apply_setting(FMT_S16, 11'd1023);     directed_burst(2);
    apply_setting(FMT_S24, 11'd512);      directed_burst(3);
    apply_setting(FMT_S24, 11'd1);        directed_burst(4);
    apply_setting(FMT_S32, 11'd1);        directed_burst(5);
    apply_setting(FMT_UNUSED, 11'd1500);  directed_burst(6);
    apply_setting(FMT_S16, GAIN_REG_MAX); directed_burst(7);
  endtask

  // Hold the output off for a long stretch while samples keep coming, so the
  // pipe fills and the input stalls.
  task automatic test_backpressure();
    apply_setting(FMT_S16, 11'd700);
    idle_on      = 1'b0;
    hold_request = 1'b1;
    repeat (32) send_sample(random_sample(fmt_cfg), random_sample(fmt_cfg),
                            1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
    idle_on = 1'b1;
  endtask

  // Random phases: a new setting per phase, every fourth phase without idling.
  task automatic test_random();
    int unsigned sent_here;
    int unsigned phase;
    int unsigned n;
    logic [1:0]  fmt;
    logic [10:0] gain;
    sent_here = 0;
    phase     = 0;
    while (sent_here < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: fmt = FMT_S16;
        3, 4, 5: fmt = FMT_S24;
        9:       fmt = FMT_UNUSED;
        default: fmt = FMT_S32;
      endcase
      case ($urandom_range(0, 9))
        0:       gain = GAIN_ZERO;
        1:       gain = 11'd1;
        2:       gain = 11'd1023;
        3:       gain = UNITY_GAIN;
        4:       gain = 11'($urandom_range(UNITY_GAIN + 1, GAIN_REG_MAX));
        default: gain = 11'($urandom_range(0, UNITY_GAIN));
      endcase
      apply_setting(fmt, gain);
      idle_on = (phase % 4 != 3);
      n = $urandom_range(15, 60);
      repeat (n) send_sample(random_sample(fmt_cfg), random_sample(fmt_cfg),
                             1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      sent_here += n;
      phase++;
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned drain_wait;
    error_count        = 0;
    samples_sent       = 0;
    results_checked    = 0;
    settings_used      = 0;
    input_stall_cycles = 0;
    idle_on            = 1'b1;
    hold_request       = 1'b0;
    hold_left          = 0;
    fmt_cfg            = FMT_S32;
    gain_cfg           = UNITY_GAIN;
    // Drive every input to a known value before the first edge.
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    source_sample_i = '0;
    sink_sample_i   = '0;
    add_to_sink_i   = 1'b0;
    last_in_block_i = 1'b0;
    out_ready_i     = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_directed();
    test_backpressure();
    test_random();

    // Stop offering, let the tail drain, then watch for stray transfers.
    in_valid_i <= 1'b0;
    drain_wait = 0;
    while (pending_mix_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain_wait++;
    end
    if (pending_mix_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_mix_q.size()));
    repeat (PIPE_LATENCY + 4) @(negedge clk_i);

    $display("Mixed %0d samples under %0d format/gain settings, %0d results compared.",
             samples_sent, settings_used, results_checked);
    $display("Input held back for %0d cycles by output stalls; %0d mismatches.",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
